@@ rtl/core/blink_pattern_sequencer_assert.svh @@
// assertion macros shared by the blink pattern sequencer rtl
`ifndef BLINK_PATTERN_SEQUENCER_ASSERT_SVH
`define BLINK_PATTERN_SEQUENCER_ASSERT_SVH

// condition holds in the same cycle
`define BPS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// condition holds in the next cycle
`define BPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/bps_pkg.sv @@
// shared constants and types of the blink pattern sequencer
package bps_pkg;

    localparam int MODE_W       = 3;
    localparam int COUNT_W      = 8;
    localparam int TIME_FIELD_W = 16;
    localparam int PAT_W        = 43;
    localparam int NUM_PAT      = 7;
    localparam int ADDR_W       = 6;
    localparam int DATA_W       = 64;

    // bit positions inside a pattern register
    localparam int OFF_LSB   = 0;
    localparam int ON_LSB    = 16;
    localparam int COUNT_LSB = 32;
    localparam int NEXT_LSB  = 40;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_ENTER = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_FOREVER = 8'hFF;
    localparam logic [MODE_W-1:0]  MODE_IDLE     = 3'd0;

    typedef logic [PAT_W-1:0] pattern_t;

    typedef struct packed {
        logic                drive_on;
        logic [MODE_W-1:0]   current_mode;
        logic [COUNT_W-1:0]  repeats_left;
    } result_t;

endpackage

@@ rtl/core/bps_req_if.sv @@
// request channel: tick or enter-mode items
interface bps_req_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [bps_pkg::MODE_W-1:0] mode;

    modport source (output valid, output func, output mode, input ready);
    modport sink   (input valid, input func, input mode, output ready);
endinterface

@@ rtl/core/bps_rsp_if.sv @@
// result channel: output level and sequencer status
interface bps_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        drive_on;
    logic [bps_pkg::MODE_W-1:0]  current_mode;
    logic [bps_pkg::COUNT_W-1:0] repeats_left;

    modport source (output valid, output drive_on, output current_mode,
                    output repeats_left, input ready);
    modport sink   (input valid, input drive_on, input current_mode,
                    input repeats_left, output ready);
endinterface

@@ rtl/core/blink_pattern_sequencer.sv @@
// blink pattern sequencer top level: pattern table, phase state and result buffering
//
// usage
//   req channel: each request is either a one millisecond tick (func = 0)
//   or an enter of pattern "mode" (func = 1). every request yields exactly
//   one result on the rsp channel: drive level, running pattern and the
//   remaining on-phase count (255 = endless).
//   pattern table: seven 43-bit registers on the apb port at byte address
//   8*i (off ms, on ms, count, next pattern); pattern 0 is the fixed idle
//   pattern. write the table only while no request is in flight.
//   result: the result of a request reaches rsp through the output register,
//   or through the skid register while rsp stalls. throughput: one request
//   per cycle while req.ready is high; the whole phase update (timer
//   countdown, repeat count, chaining, toggle, timer reload) is one
//   combinational pass into the state and result registers. stall: a two-deep
//   result buffer (output register plus skid register) keeps req ready while
//   one result waits; req.ready drops only when both hold a result, and rises again once rsp takes one.
//   reset: pattern idle, output off, counters and timer zero, table cleared,
//   no result pending.
module blink_pattern_sequencer #(
    parameter int TIME_WIDTH = 16,
    parameter int NUM_MODES  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    bps_req_if.sink                      req,
    bps_rsp_if.source                    rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bps_pkg::ADDR_W-1:0]   paddr,
    input  logic [bps_pkg::DATA_W-1:0]   pwdata,
    output logic [bps_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam logic [TIME_WIDTH-1:0] TIMER_MAX   = '1;
    localparam logic [31:0]           TIMER_MAX32 = 32'(TIMER_MAX);
    localparam logic [TIME_WIDTH-1:0] TIMER_ONE   = {{(TIME_WIDTH-1){1'b0}}, 1'b1};

    // pattern table, index 0 holds pattern 1
    bps_pkg::pattern_t pat_reg [bps_pkg::NUM_PAT];

    // running state
    logic [bps_pkg::MODE_W-1:0]  mode_reg,  mode_next;
    logic [bps_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        level_reg, level_next;
    logic [TIME_WIDTH-1:0]       timer_reg, timer_next;

    // result buffer
    logic                out_valid_reg;
    bps_pkg::result_t    out_data_reg;
    logic                skid_valid_reg;
    bps_pkg::result_t    skid_data_reg;
    bps_pkg::result_t    result;

    logic req_fire;
    logic rsp_fire;
    logic cfg_write;
    logic [2:0] cfg_idx;

    // ---------------------------------------------------------------
    // apb port: register index from the 8-byte aligned address
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[5:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bps_pkg::NUM_PAT; i++)
            begin
                pat_reg[i] <= '0;
            end
        end
        else if (cfg_write && (cfg_idx != 3'd7))
        begin
            pat_reg[cfg_idx] <= pwdata[bps_pkg::PAT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_idx != 3'd7)
        begin
            prdata = {{(bps_pkg::DATA_W-bps_pkg::PAT_W){1'b0}}, pat_reg[cfg_idx]};
        end
    end

    // ---------------------------------------------------------------
    // pattern helpers
    // ---------------------------------------------------------------
    // pattern numbers at or above NUM_MODES fall back to idle
    function automatic logic [bps_pkg::MODE_W-1:0] legal_mode(
        input logic [bps_pkg::MODE_W-1:0] m
    );
        if ({1'b0, m} >= 4'(NUM_MODES))
            return bps_pkg::MODE_IDLE;
        return m;
    endfunction

    // times wider than the timer saturate
    function automatic logic [TIME_WIDTH-1:0] sat_time(
        input logic [bps_pkg::TIME_FIELD_W-1:0] t
    );
        logic [31:0] t32;
        t32 = {16'b0, t};
        if (t32 > TIMER_MAX32)
            return TIMER_MAX;
        return t32[TIME_WIDTH-1:0];
    endfunction

    bps_pkg::pattern_t           cur_pat;
    bps_pkg::pattern_t           new_pat;
    bps_pkg::pattern_t           enter_pat;
    logic [bps_pkg::MODE_W-1:0]  enter_mode;
    logic [bps_pkg::MODE_W-1:0]  chain_mode;

    // pattern of the running mode
    assign cur_pat = (mode_reg == bps_pkg::MODE_IDLE) ? '0 : pat_reg[mode_reg - 3'd1];

    // pattern entered by an enter request
    assign enter_mode = legal_mode(req.mode);
    assign enter_pat  = (enter_mode == bps_pkg::MODE_IDLE) ? '0 : pat_reg[enter_mode - 3'd1];

    // ---------------------------------------------------------------
    // phase update
    // ---------------------------------------------------------------
    logic [TIME_WIDTH-1:0]       timer_dec;
    logic [bps_pkg::COUNT_W-1:0] count_dec;
    logic                        do_chain;
    logic [bps_pkg::COUNT_W-1:0] count_fire;
    logic [bps_pkg::MODE_W-1:0]  mode_fire;
    logic                        level_fire;

    assign timer_dec = (timer_reg != '0) ? (timer_reg - TIMER_ONE) : timer_reg;

    // completed on phase uses up one repeat, endless count stays
    assign count_dec = (level_reg && (count_reg != '0) && (count_reg != bps_pkg::COUNT_FOREVER))
                       ? (count_reg - 8'd1) : count_reg;
    assign do_chain   = (count_dec == '0);
    assign chain_mode = legal_mode(cur_pat[bps_pkg::NEXT_LSB +: bps_pkg::MODE_W]);
    assign mode_fire  = do_chain ? chain_mode : mode_reg;
    assign new_pat    = (mode_fire == bps_pkg::MODE_IDLE) ? '0 : pat_reg[mode_fire - 3'd1];
    assign count_fire = do_chain ? new_pat[bps_pkg::COUNT_LSB +: bps_pkg::COUNT_W] : count_dec;

    // zero off time with repeats left means steady on
    assign level_fire = ((count_fire != '0) &&
                         (new_pat[bps_pkg::OFF_LSB +: bps_pkg::TIME_FIELD_W] == '0))
                        ? 1'b1 : !level_reg;

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        level_next = level_reg;
        timer_next = timer_reg;
        if (req.func == bps_pkg::FUNC_ENTER)
        begin
            mode_next  = enter_mode;
            count_next = enter_pat[bps_pkg::COUNT_LSB +: bps_pkg::COUNT_W];
            level_next = 1'b0;
            timer_next = '0;
        end
        else if (mode_reg != bps_pkg::MODE_IDLE)
        begin
            timer_next = timer_dec;
            if (timer_dec == '0)
            begin
                mode_next  = mode_fire;
                count_next = count_fire;
                level_next = level_fire;
                timer_next = level_fire
                    ? sat_time(new_pat[bps_pkg::ON_LSB +: bps_pkg::TIME_FIELD_W])
                    : sat_time(new_pat[bps_pkg::OFF_LSB +: bps_pkg::TIME_FIELD_W]);
            end
        end
    end

    assign result.drive_on     = level_next;
    assign result.current_mode = mode_next;
    assign result.repeats_left = count_next;

    // ---------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------
    // skid register free means a request can always be absorbed
    assign req.ready = !skid_valid_reg;
    assign req_fire  = req.valid && req.ready;
    assign rsp_fire  = rsp.valid && rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= bps_pkg::MODE_IDLE;
            count_reg <= '0;
            level_reg <= 1'b0;
            timer_reg <= '0;
        end
        else if (req_fire)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            level_reg <= level_next;
            timer_reg <= timer_next;
        end
    end

    // result valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || rsp_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= req_fire;
            end
        end
        else if (req_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || rsp_fire)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (req_fire)
            begin
                out_data_reg <= result;
            end
        end
        else if (req_fire)
        begin
            skid_data_reg <= result;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.drive_on     = out_data_reg.drive_on;
    assign rsp.current_mode = out_data_reg.current_mode;
    assign rsp.repeats_left = out_data_reg.repeats_left;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `include "blink_pattern_sequencer_assert.svh"

    `BPS_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid full while output empty")
    `BPS_ASSERT_NEXT(a_idle_holds, clk, rst_n, req_fire && (req.func == bps_pkg::FUNC_TICK) && (mode_reg == bps_pkg::MODE_IDLE), (mode_reg == bps_pkg::MODE_IDLE) && (level_reg == $past(level_reg)), "idle tick changed state")
    `BPS_ASSERT_NEXT(a_endless_stays, clk, rst_n, req_fire && (req.func == bps_pkg::FUNC_TICK) && (mode_reg != bps_pkg::MODE_IDLE) && (count_reg == bps_pkg::COUNT_FOREVER), (count_reg == bps_pkg::COUNT_FOREVER) && (mode_reg == $past(mode_reg)), "endless pattern left its mode")
    `BPS_ASSERT_NEXT(a_enter_arms, clk, rst_n, req_fire && (req.func == bps_pkg::FUNC_ENTER), (timer_reg == '0) && !level_reg, "enter did not arm the next tick")

endmodule

@@ test/testbench.sv @@
// testbench for the blink pattern sequencer: directed table, random phases, self-checking
`timescale 1ns / 1ps

module testbench;

    // a run with nothing moving on any port for this many cycles is hung
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 100;
    localparam int PRESSURE_HOLD = 60;

    typedef logic [bps_pkg::DATA_W-1:0] word_t;
    typedef logic [bps_pkg::MODE_W-1:0] mode_t;

    // ways to fill a pattern register in the random part
    typedef enum int {STYLE_SHORT, STYLE_ONES, STYLE_ZERO, STYLE_WILD} pattern_style_t;

    // one row of the directed table: either a request or a register write
    typedef struct {
        bit                          is_cfg;
        logic                        func;
        logic [bps_pkg::MODE_W-1:0]  mode;
        int                          idx;
        logic [bps_pkg::DATA_W-1:0]  value;
        bit                          typed;
        bps_pkg::result_t            want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [bps_pkg::ADDR_W-1:0] paddr;
    logic [bps_pkg::DATA_W-1:0] pwdata;
    logic [bps_pkg::DATA_W-1:0] prdata;
    logic pready;

    bps_req_if req_ch ();
    bps_rsp_if rsp_ch ();

    blink_pattern_sequencer i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // own copy of the sequencer: pattern table and running state
    bps_pkg::pattern_t                 pat_tbl [1:bps_pkg::NUM_PAT];
    logic [bps_pkg::MODE_W-1:0]        seq_mode;
    logic [bps_pkg::COUNT_W-1:0]       seq_count;
    logic                              seq_level;
    logic [bps_pkg::TIME_FIELD_W-1:0]  seq_timer;

    bps_pkg::result_t expected_status [$];
    plan_row_t        directed_plan [$];
    int               mismatch_count = 0;
    int               quiet_cycles = 0;
    bit               gaps_on;
    bit               hold_response;

    always #2 clk = ~clk;

    // pattern 0 is the fixed idle entry, all zero
    function automatic bps_pkg::pattern_t pattern_at(logic [bps_pkg::MODE_W-1:0] m);
        if (m == bps_pkg::MODE_IDLE)
            return '0;
        return pat_tbl[m];
    endfunction

    // advance the predicted sequencer by one request and return its status
    function automatic bps_pkg::result_t step_blinker(logic func,
                                                      logic [bps_pkg::MODE_W-1:0] mode);
        bps_pkg::pattern_t p;
        bps_pkg::result_t  r;
        if (func == bps_pkg::FUNC_ENTER)
        begin
            // enter: load the count, output off, timer zero so the next tick fires
            p         = pattern_at(mode);
            seq_mode  = mode;
            seq_count = p[bps_pkg::COUNT_LSB +: bps_pkg::COUNT_W];
            seq_level = 1'b0;
            seq_timer = '0;
        end
        else if (seq_mode != bps_pkg::MODE_IDLE)
        begin
            if (seq_timer != 0)
                seq_timer = seq_timer - 1'b1;
            if (seq_timer == 0)
            begin
                // a completed on phase uses up one repeat unless endless
                if (seq_level && seq_count != 0 && seq_count != bps_pkg::COUNT_FOREVER)
                    seq_count = seq_count - 1'b1;
                // count used up: chain to the next pattern (may be idle)
                if (seq_count == 0)
                begin
                    p         = pattern_at(seq_mode);
                    seq_mode  = p[bps_pkg::NEXT_LSB +: bps_pkg::MODE_W];
                    p         = pattern_at(seq_mode);
                    seq_count = p[bps_pkg::COUNT_LSB +: bps_pkg::COUNT_W];
                end
                p = pattern_at(seq_mode);
                // zero off time means the output stays on
                if (seq_count != 0 && p[bps_pkg::OFF_LSB +: bps_pkg::TIME_FIELD_W] == 0)
                    seq_level = 1'b1;
                else
                    seq_level = ~seq_level;
                seq_timer = seq_level ? p[bps_pkg::ON_LSB +: bps_pkg::TIME_FIELD_W]
                                      : p[bps_pkg::OFF_LSB +: bps_pkg::TIME_FIELD_W];
            end
        end
        r.drive_on     = seq_level;
        r.current_mode = seq_mode;
        r.repeats_left = seq_count;
        return r;
    endfunction

    function automatic void check_field(string what, logic [bps_pkg::DATA_W-1:0] want,
                                        logic [bps_pkg::DATA_W-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, what, want, got);
        end
    endfunction

    function automatic logic [bps_pkg::DATA_W-1:0] pack_pattern(int off_ms, int on_ms,
                                                                 int cnt, int nxt);
        logic [bps_pkg::DATA_W-1:0] v;
        v = '0;
        v[bps_pkg::OFF_LSB +: bps_pkg::TIME_FIELD_W] = off_ms[bps_pkg::TIME_FIELD_W-1:0];
        v[bps_pkg::ON_LSB +: bps_pkg::TIME_FIELD_W]  = on_ms[bps_pkg::TIME_FIELD_W-1:0];
        v[bps_pkg::COUNT_LSB +: bps_pkg::COUNT_W]    = cnt[bps_pkg::COUNT_W-1:0];
        v[bps_pkg::NEXT_LSB +: bps_pkg::MODE_W]      = nxt[bps_pkg::MODE_W-1:0];
        return v;
    endfunction

    function automatic bps_pkg::result_t status(logic drv, logic [bps_pkg::MODE_W-1:0] md,
                                                logic [bps_pkg::COUNT_W-1:0] rep);
        bps_pkg::result_t r;
        r.drive_on     = drv;
        r.current_mode = md;
        r.repeats_left = rep;
        return r;
    endfunction

    function automatic void plan_request(logic func, logic [bps_pkg::MODE_W-1:0] mode,
                                         bit typed, bps_pkg::result_t want);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.func   = func;
        row.mode   = mode;
        row.idx    = 0;
        row.value  = '0;
        row.typed  = typed;
        row.want   = want;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_config(int idx, logic [bps_pkg::DATA_W-1:0] value);
        plan_row_t row;
        row.is_cfg = 1'b1;
        row.func   = bps_pkg::FUNC_TICK;
        row.mode   = bps_pkg::MODE_IDLE;
        row.idx    = idx;
        row.value  = value;
        row.typed  = 1'b0;
        row.want   = '0;
        directed_plan.push_back(row);
    endfunction

    // short times most of the time so that phases fire often
    function automatic logic [bps_pkg::DATA_W-1:0] random_pattern(pattern_style_t style);
        logic [bps_pkg::DATA_W-1:0] v;
        logic [bps_pkg::DATA_W-1:0] junk;
        int                         pick;
        int                         cnt;
        case (style)
            STYLE_ONES: v = '1;
            STYLE_ZERO: v = '0;
            STYLE_WILD: v = {$urandom, $urandom};
            default:
            begin
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    cnt = 0;
                else if (pick < 4)
                    cnt = int'(bps_pkg::COUNT_FOREVER);
                else
                    cnt = $urandom_range(1, 4);
                v = pack_pattern($urandom_range(0, 3), $urandom_range(0, 3), cnt,
                                 $urandom_range(0, 7));
                // bits above the register should simply be dropped
                if ($urandom_range(0, 3) == 0)
                begin
                    junk = {$urandom, $urandom};
                    v[bps_pkg::DATA_W-1:bps_pkg::PAT_W] =
                        junk[bps_pkg::DATA_W-bps_pkg::PAT_W-1:0];
                end
            end
        endcase
        return v;
    endfunction

    // one apb transfer: setup cycle, then access until pready
    task automatic apb_transfer(bit wr, int idx, logic [bps_pkg::DATA_W-1:0] wdata,
                                output logic [bps_pkg::DATA_W-1:0] rdata);
        int byte_addr;
        byte_addr = idx * 8;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= byte_addr[bps_pkg::ADDR_W-1:0];
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // write a pattern register and read it back; indexes past the table are ignored
    task automatic load_pattern(int idx, logic [bps_pkg::DATA_W-1:0] value);
        logic [bps_pkg::DATA_W-1:0] rd;
        apb_transfer(1'b1, idx, value, rd);
        if (idx < bps_pkg::NUM_PAT)
        begin
            pat_tbl[idx + 1] = value[bps_pkg::PAT_W-1:0];
            apb_transfer(1'b0, idx, '0, rd);
            check_field("pattern readback",
                        {{(bps_pkg::DATA_W-bps_pkg::PAT_W){1'b0}}, value[bps_pkg::PAT_W-1:0]},
                        {{(bps_pkg::DATA_W-bps_pkg::PAT_W){1'b0}}, rd[bps_pkg::PAT_W-1:0]});
        end
    endtask

    // stop offering and let every outstanding result come back
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // offer one request, possibly after an idle burst, and predict it when taken
    task automatic send_request(logic func, logic [bps_pkg::MODE_W-1:0] mode, bit typed,
                                bps_pkg::result_t want);
        bps_pkg::result_t predicted;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= func;
        req_ch.mode  <= mode;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = step_blinker(func, mode);
        expected_status.push_back(typed ? want : predicted);
    endtask

    // result side: ready with random stall bursts, and one long hold on demand
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_response)
            begin
                // long hold while the sender keeps offering: the buffer fills up
                rsp_ch.ready <= 1'b0;
                repeat (PRESSURE_HOLD) @(posedge clk);
                hold_response = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    // result checker and hang watchdog
    always @(posedge clk)
    begin
        bps_pkg::result_t got;
        bps_pkg::result_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.drive_on     = rsp_ch.drive_on;
                got.current_mode = rsp_ch.current_mode;
                got.repeats_left = rsp_ch.repeats_left;
                if (expected_status.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none actual %p",
                             $realtime, got);
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("drive_on", word_t'(want.drive_on), word_t'(got.drive_on));
                    check_field("current_mode", word_t'(want.current_mode),
                                word_t'(got.current_mode));
                    check_field("repeats_left", word_t'(want.repeats_left),
                                word_t'(got.repeats_left));
                end
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        plan_row_t      row;
        pattern_style_t style;
        logic           func;

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_ch.valid   = 1'b0;
        req_ch.func    = bps_pkg::FUNC_TICK;
        req_ch.mode    = bps_pkg::MODE_IDLE;
        gaps_on        = 1'b1;
        hold_response  = 1'b0;
        for (int m = 1; m <= bps_pkg::NUM_PAT; m++)
            pat_tbl[m] = '0;
        seq_mode  = bps_pkg::MODE_IDLE;
        seq_count = '0;
        seq_level = 1'b0;
        seq_timer = '0;

        // directed table: typed results are the ones plain from reset and extremes
        // tick in idle after reset leaves everything at zero
        plan_request(bps_pkg::FUNC_TICK, 3'd0, 1'b1, status(1'b0, 3'd0, 8'd0));
        // empty pattern: entered with zero count, output off
        plan_request(bps_pkg::FUNC_ENTER, 3'd5, 1'b1, status(1'b0, 3'd5, 8'd0));
        // chain into idle still toggles the output on, then idle holds it
        plan_request(bps_pkg::FUNC_TICK, 3'd0, 1'b1, status(1'b1, 3'd0, 8'd0));
        plan_request(bps_pkg::FUNC_TICK, 3'd7, 1'b1, status(1'b1, 3'd0, 8'd0));
        plan_request(bps_pkg::FUNC_ENTER, 3'd0, 1'b1, status(1'b0, 3'd0, 8'd0));
        // two repeats chaining into an endless pattern with zero off time
        plan_config(0, pack_pattern(2, 1, 2, 2));
        plan_config(1, pack_pattern(0, 3, int'(bps_pkg::COUNT_FOREVER), 0));
        // all ones, including bits above the register
        plan_config(6, '1);
        // one repeat chaining into a pattern with zero count
        plan_config(2, pack_pattern(1, 1, 1, 6));
        // address past the table is ignored
        plan_config(bps_pkg::NUM_PAT, '1);
        plan_request(bps_pkg::FUNC_ENTER, 3'd1, 1'b0, '0);
        repeat (8) plan_request(bps_pkg::FUNC_TICK, 3'd2, 1'b0, '0);
        plan_request(bps_pkg::FUNC_ENTER, 3'd7, 1'b1,
                     status(1'b0, 3'd7, bps_pkg::COUNT_FOREVER));
        plan_request(bps_pkg::FUNC_TICK, 3'd0, 1'b1,
                     status(1'b1, 3'd7, bps_pkg::COUNT_FOREVER));
        plan_request(bps_pkg::FUNC_TICK, 3'd0, 1'b1,
                     status(1'b1, 3'd7, bps_pkg::COUNT_FOREVER));
        plan_request(bps_pkg::FUNC_ENTER, 3'd3, 1'b0, '0);
        repeat (3) plan_request(bps_pkg::FUNC_TICK, 3'd4, 1'b0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            row = directed_plan[i];
            if (row.is_cfg)
            begin
                // registers change only with nothing in flight
                settle();
                load_pattern(row.idx, row.value);
            end
            else
                send_request(row.func, row.mode, row.typed, row.want);
        end

        // random phases, each with a fresh pattern table
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            gaps_on = (p % 3 != 2) && (p != PHASES - 1);
            for (int idx = 0; idx < bps_pkg::NUM_PAT; idx++)
            begin
                if (p == 1)
                    style = STYLE_ONES;
                else if (p == 2)
                    style = STYLE_ZERO;
                else
                    style = ($urandom_range(0, 6) == 0) ? STYLE_WILD : STYLE_SHORT;
                load_pattern(idx, random_pattern(style));
            end
            // first phase: receiver holds off with the sender running flat out
            if (p == 0)
            begin
                gaps_on       = 1'b0;
                hold_response = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                func = ($urandom_range(0, 99) < 85) ? bps_pkg::FUNC_TICK
                                                    : bps_pkg::FUNC_ENTER;
                send_request(func, mode_t'($urandom_range(0, 7)), 1'b0, '0);
                if (p == 0 && n == 40)
                    gaps_on = 1'b1;
            end
        end

        // drain, then keep clocking so that any extra result from the block would show
        settle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
